[design/gs_pkg.sv]
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package gs_pkg;

   // system size and derived widths
   localparam int MAX_N  = 16;
   localparam int IDX_W  = $clog2(MAX_N);
   localparam int CNT_W  = $clog2(MAX_N + 1);
   localparam int ADDR_W = $clog2(MAX_N * MAX_N);

   // operation codes of an input word
   localparam logic [1:0] OP_COEF  = 2'd0;
   localparam logic [1:0] OP_RHS   = 2'd1;
   localparam logic [1:0] OP_SOLVE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_CONV  = 2'd0;
   localparam logic [1:0] ST_CAP   = 2'd1;
   localparam logic [1:0] ST_ZDIAG = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_TOL   = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic             coef_we;
      logic             rhs_we;
      logic             x_clear;
      logic             diag_issue;
      logic             mac_issue;
      logic             acc_clear;
      logic             div_start;
      logic             x_write;
      logic             moved_clear;
      logic             emit_load;
      logic             emit_last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [1:0]       status;
      logic [15:0]      iters;
      logic [15:0]      tol;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic diag_zero;
      logic div_done;
      logic moved;
      logic rsp_busy;
   } dp_stat_type;

endpackage

[design/gs_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module gs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gs_dp.sv]
// datapath: stores, multiply-accumulate pipe, serial divider, result register
`timescale 1ns / 1ps

module gs_dp import gs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_column_index,
   input  logic signed [31:0] req_value,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [3:0]         rsp_unknown_index,
   output logic signed [31:0] rsp_unknown_value,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_iterations_used,
   output logic               rsp_last
);

   localparam logic signed [63:0] CLAMP_POS = 64'sd1 <<< 46;
   localparam logic signed [63:0] CLAMP_NEG = -(64'sd1 <<< 46);

   // write address decode
   logic [IDX_W-1:0]  wr_row;
   logic [IDX_W-1:0]  wr_col;
   logic              wr_row_ok;
   logic              wr_col_ok;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [31:0]       ram_rdata;

   assign wr_row      = IDX_W'(req_row_index);
   assign wr_col      = IDX_W'(req_column_index);
   assign wr_row_ok   = 32'(req_row_index) < 32'(MAX_N);
   assign wr_col_ok   = 32'(req_column_index) < 32'(MAX_N);
   assign ram_wr_addr = ADDR_W'(wr_row) * ADDR_W'(MAX_N) + ADDR_W'(wr_col);
   assign ram_rd_addr = ADDR_W'(cmd.row) * ADDR_W'(MAX_N) + ADDR_W'(cmd.col);

   gs_ram #(.WIDTH(32), .DEPTH(MAX_N * MAX_N)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_we && wr_row_ok && wr_col_ok),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.diag_issue || cmd.mac_issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   assign stat.diag_zero = (ram_rdata == 32'd0);

   // right-hand side store
   logic signed [31:0] rhs_ff [MAX_N];

   always_ff @(posedge clock) begin
      if (cmd.rhs_we && wr_row_ok) begin
         rhs_ff[wr_row] <= req_value;
      end
   end

   // unknown store, one read mux
   logic signed [31:0] x_ff [MAX_N];
   logic [IDX_W-1:0]   x_rd_idx;
   logic signed [31:0] x_rd;
   logic signed [31:0] fresh_ff;

   logic [IDX_W-1:0]   p0_col_ff;
   assign x_rd_idx = cmd.emit_load ? cmd.col : p0_col_ff;
   assign x_rd     = x_ff[x_rd_idx];

   always_ff @(posedge clock) begin
      if (reset || cmd.x_clear) begin
         for (int k = 0; k < MAX_N; k++) begin
            x_ff[k] <= 32'sd0;
         end
      end else if (cmd.x_write) begin
         x_ff[cmd.row] <= fresh_ff;
      end
   end

   // multiply-accumulate pipe
   logic               p0_valid_ff;
   logic               p1_valid_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] prod_q;
   logic signed [63:0] acc_ff;
   logic signed [31:0] diag_ff;
   logic signed [31:0] old_ff;
   logic signed [31:0] a_val;

   assign a_val   = ram_rdata;
   assign prod_in = a_val * x_rd;
   // product truncated toward zero
   assign prod_q  = (prod_ff >>> 16) +
                    ((prod_ff[63] && (prod_ff[15:0] != 16'd0)) ? 64'sd1 : 64'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= cmd.mac_issue;
         p1_valid_ff <= p0_valid_ff;
      end
      p0_col_ff <= cmd.col;
      if (p0_valid_ff && (p0_col_ff == cmd.row)) begin
         prod_ff <= 64'sd0;
         diag_ff <= a_val;
         old_ff  <= x_rd;
      end else begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_clear) begin
         acc_ff <= 64'sd0;
      end else if (p1_valid_ff) begin
         acc_ff <= acc_ff + prod_q;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic signed [63:0] num_in;
   logic signed [63:0] num_ff;
   logic signed [63:0] num_abs;
   logic               load_ff;
   logic               busy_ff;
   logic               fin_ff;
   logic               done_ff;
   logic               sign_ff;
   logic [5:0]         cnt_ff;
   logic [32:0]        rem_ff;
   logic [62:0]        quo_ff;
   logic [31:0]        dmag_ff;
   logic [32:0]        rem_sh;
   logic               ge;
   logic signed [31:0] sat_val;

   assign num_in  = 64'(rhs_ff[cmd.row]) - acc_ff;
   assign num_abs = num_ff[63] ? -num_ff : num_ff;
   assign rem_sh  = {rem_ff[31:0], quo_ff[62]};
   assign ge      = rem_sh >= {1'b0, dmag_ff};

   // saturate the signed quotient
   always_comb begin
      if (sign_ff) begin
         if (quo_ff > 63'h0000_0000_8000_0000) begin
            sat_val = 32'sh8000_0000;
         end else begin
            sat_val = -$signed(quo_ff[31:0]);
         end
      end else begin
         if (quo_ff > 63'h0000_0000_7FFF_FFFF) begin
            sat_val = 32'sh7FFF_FFFF;
         end else begin
            sat_val = $signed(quo_ff[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= cmd.div_start;
         fin_ff  <= busy_ff && (cnt_ff == 6'd62);
         done_ff <= fin_ff;
         if (load_ff) begin
            busy_ff <= 1'b1;
         end else if (cnt_ff == 6'd62) begin
            busy_ff <= 1'b0;
         end
      end
      if (cmd.div_start) begin
         if (num_in > CLAMP_POS) begin
            num_ff <= CLAMP_POS;
         end else if (num_in < CLAMP_NEG) begin
            num_ff <= CLAMP_NEG;
         end else begin
            num_ff <= num_in;
         end
      end
      if (load_ff) begin
         quo_ff  <= {num_abs[46:0], 16'd0};
         rem_ff  <= 33'd0;
         cnt_ff  <= 6'd0;
         sign_ff <= num_ff[63] ^ diag_ff[31];
         dmag_ff <= diag_ff[31] ? (~diag_ff + 32'd1) : diag_ff;
      end else if (busy_ff) begin
         rem_ff <= ge ? (rem_sh - {1'b0, dmag_ff}) : rem_sh;
         quo_ff <= {quo_ff[61:0], ge};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (fin_ff) begin
         fresh_ff <= sat_val;
      end
   end

   assign stat.div_done = done_ff;

   // change test against tolerance
   logic signed [32:0] diff;
   logic [32:0]        diff_abs;
   logic               moved_ff;

   assign diff     = 33'(fresh_ff) - 33'(old_ff);
   assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

   always_ff @(posedge clock) begin
      if (reset || cmd.moved_clear) begin
         moved_ff <= 1'b0;
      end else if (cmd.x_write && (diff_abs > 33'(cmd.tol))) begin
         moved_ff <= 1'b1;
      end
   end

   assign stat.moved = moved_ff;

   // result register
   logic               rsp_valid_ff;
   logic [3:0]         rsp_idx_ff;
   logic signed [31:0] rsp_val_ff;
   logic [1:0]         rsp_st_ff;
   logic [15:0]        rsp_it_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_load) begin
         rsp_idx_ff  <= 4'(cmd.col);
         rsp_val_ff  <= x_rd;
         rsp_st_ff   <= cmd.status;
         rsp_it_ff   <= cmd.iters;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign stat.rsp_busy       = rsp_valid_ff && !rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_unknown_index   = rsp_idx_ff;
   assign rsp_unknown_value   = rsp_val_ff;
   assign rsp_status          = rsp_st_ff;
   assign rsp_iterations_used = rsp_it_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

[design/gs_ctrl.sv]
// controller: register file, solve sequencing and result emission
`timescale 1ns / 1ps

module gs_ctrl import gs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_DCHK, S_DCHK_W, S_SWEEP, S_ROW, S_MAC, S_DRAIN,
      S_DIV, S_DIV_WAIT, S_COMMIT, S_CHECK, S_EMIT
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] i_ff;
   logic [IDX_W-1:0] j_ff;
   logic [IDX_W-1:0] top_ff;
   logic [15:0]      limit_ff;
   logic [15:0]      count_ff;
   logic [1:0]       status_ff;
   logic             zdiag_ff;
   logic             drain_ff;
   logic [4:0]       size_ff;
   logic [15:0]      tol_ff;
   logic [15:0]      lim_reg_ff;

   logic             solve_go;
   logic [CNT_W-1:0] n_sel;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign solve_go  = req_valid && req_ready && (req_operation == OP_SOLVE);

   // clamp size to the supported range
   always_comb begin
      if (size_ff == 5'd0) begin
         n_sel = CNT_W'(1);
      end else if (32'(size_ff) > 32'(MAX_N)) begin
         n_sel = CNT_W'(MAX_N);
      end else begin
         n_sel = CNT_W'(size_ff);
      end
   end

   // command decode
   always_comb begin
      cmd        = '0;
      cmd.row    = i_ff;
      cmd.col    = j_ff;
      cmd.status = status_ff;
      cmd.iters  = count_ff;
      cmd.tol    = tol_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.coef_we = req_valid && (req_operation == OP_COEF);
            cmd.rhs_we  = req_valid && (req_operation == OP_RHS);
            cmd.x_clear = solve_go;
         end
         S_DCHK: begin
            cmd.diag_issue = 1'b1;
            cmd.col        = i_ff;
         end
         S_SWEEP:  cmd.moved_clear = 1'b1;
         S_ROW:    cmd.acc_clear   = 1'b1;
         S_MAC:    cmd.mac_issue   = 1'b1;
         S_DIV:    cmd.div_start   = 1'b1;
         S_COMMIT: cmd.x_write     = 1'b1;
         S_EMIT: begin
            cmd.emit_load = !stat.rsp_busy;
            cmd.emit_last = (j_ff == top_ff);
         end
         default: begin
         end
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         i_ff       <= '0;
         j_ff       <= '0;
         top_ff     <= '0;
         limit_ff   <= 16'd1;
         count_ff   <= 16'd0;
         status_ff  <= ST_CONV;
         zdiag_ff   <= 1'b0;
         drain_ff   <= 1'b0;
         size_ff    <= 5'd16;
         tol_ff     <= 16'd1;
         lim_reg_ff <= 16'd1000;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SIZE:  size_ff    <= csr_data[4:0];
               CSR_TOL:   tol_ff     <= csr_data;
               CSR_LIMIT: lim_reg_ff <= csr_data;
               default: begin
               end
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (solve_go) begin
                  top_ff    <= IDX_W'(n_sel - CNT_W'(1));
                  limit_ff  <= (lim_reg_ff == 16'd0) ? 16'd1 : lim_reg_ff;
                  count_ff  <= 16'd0;
                  zdiag_ff  <= 1'b0;
                  i_ff      <= '0;
                  state_ff  <= S_DCHK;
               end
            end
            S_DCHK: state_ff <= S_DCHK_W;
            S_DCHK_W: begin
               if (i_ff == top_ff) begin
                  if (zdiag_ff || stat.diag_zero) begin
                     status_ff <= ST_ZDIAG;
                     j_ff      <= '0;
                     state_ff  <= S_EMIT;
                  end else begin
                     state_ff <= S_SWEEP;
                  end
               end else begin
                  zdiag_ff <= zdiag_ff || stat.diag_zero;
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_DCHK;
               end
            end
            S_SWEEP: begin
               count_ff <= count_ff + 16'd1;
               i_ff     <= '0;
               state_ff <= S_ROW;
            end
            S_ROW: begin
               j_ff     <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               if (j_ff == top_ff) begin
                  drain_ff <= 1'b0;
                  state_ff <= S_DRAIN;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               if (drain_ff) begin
                  state_ff <= S_DIV;
               end else begin
                  drain_ff <= 1'b1;
               end
            end
            S_DIV: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               if (i_ff == top_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_ROW;
               end
            end
            S_CHECK: begin
               if (stat.moved && (count_ff < limit_ff)) begin
                  state_ff <= S_SWEEP;
               end else begin
                  status_ff <= stat.moved ? ST_CAP : ST_CONV;
                  j_ff      <= '0;
                  state_ff  <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!stat.rsp_busy) begin
                  if (j_ff == top_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[design/gauss_seidel_solver_core.sv]
// top level of the gauss-seidel solver core
//
//   channel | ports   | direction | word
//   --------+---------+-----------+----------------------------------------
//   request | req_*   | in        | operation, row, column, value
//   result  | rsp_*   | out       | index, unknown, status, sweeps, last
//   config  | csr_*   | in        | register index, data (always ready)
//
// coefficient and right-hand side writes are accepted back to back while idle.
// a solve first checks every diagonal in turn, then runs sweeps: in each
// sweep every row runs a multiply-accumulate pass and a serial divide,
// which sets the pace. results leave one per cycle while rsp_ready is high.
// synchronous reset clears control state and the unknowns; stores keep data.
// a stalled result holds its register; requests wait until the run ends.
`timescale 1ns / 1ps

module gauss_seidel_solver_core import gs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_column_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_unknown_index,
   output logic signed [31:0] rsp_unknown_value,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_iterations_used,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing
   gs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd           (cmd),
      .stat          (stat)
   );

   // arithmetic and storage
   gs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_row_index       (req_row_index),
      .req_column_index    (req_column_index),
      .req_value           (req_value),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_unknown_index   (rsp_unknown_index),
      .rsp_unknown_value   (rsp_unknown_value),
      .rsp_status          (rsp_status),
      .rsp_iterations_used (rsp_iterations_used),
      .rsp_last            (rsp_last)
   );

endmodule

[design/gs_check.sv]
// port-level checker for the solver core and its bind
`timescale 1ns / 1ps

module gs_check import gs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_operation,
   input logic [3:0]         req_row_index,
   input logic [3:0]         req_column_index,
   input logic signed [31:0] req_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_unknown_index,
   input logic signed [31:0] rsp_unknown_value,
   input logic [1:0]         rsp_status,
   input logic [15:0]        rsp_iterations_used,
   input logic               rsp_last,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [1:0]         csr_index,
   input logic [15:0]        csr_data
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unknown_value)
         && $stable(rsp_unknown_index) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // zero diagonal runs no sweep
   a_zdiag_iter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ZDIAG) |-> rsp_iterations_used == 16'd0)
      else $error("zero diagonal status with nonzero sweep count");

   // a converged run did at least one sweep
   a_conv_iter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CONV) |-> rsp_iterations_used != 16'd0)
      else $error("converged status with zero sweeps");

   // results of a run follow in index order with no gap
   a_index_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_unknown_index == $past(rsp_unknown_index) + 4'd1))
      else $error("result index out of sequence");

endmodule

bind gauss_seidel_solver_core gs_check u_gs_check (.*);
